[rtl/slbm_pkg.sv]
// slbm_pkg: shared types and constants for the serial loaded bank mapper.
// No dependencies; used by slbm_map and serial_loaded_bank_mapper.
`default_nettype none

package slbm_pkg;

    // Bus access kinds
    typedef enum logic [1:0] {
        KIND_CPU_READ  = 2'd0,
        KIND_CPU_WRITE = 2'd1,
        KIND_PPU_READ  = 2'd2,
        KIND_PPU_WRITE = 2'd3
    } slbm_kind_t;

    // Result target codes
    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_ROM = 3'd1,
        TGT_PRG_RAM = 3'd2,
        TGT_CHR     = 3'd3,
        TGT_REG     = 3'd4
    } slbm_target_t;

    // Configuration register indexes
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    // Serial register select (address bits 14:13)
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } slbm_sel_t;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 22;
    localparam int BANK_W   = 5;

    localparam logic [BANK_W-1:0] SHIFT_RESET   = 5'h10;
    localparam logic [BANK_W-1:0] CONTROL_RESET = 5'h0C;
    localparam logic [7:0]        PRG_CNT_RESET = 8'd2;
    localparam logic [7:0]        CHR_CNT_RESET = 8'd0;

    // One accepted access
    typedef struct packed {
        slbm_kind_t          kind;
        logic [ADDR_W-1:0]   addr;
        logic [DATA_W-1:0]   write_data;
    } slbm_item_t;

    // One result
    typedef struct packed {
        logic                handled;
        slbm_target_t        target;
        logic [MAP_W-1:0]    mapped_address;
        logic                mirror_update;
        logic [1:0]          mirror_mode;
    } slbm_result_t;

endpackage

`default_nettype wire

[rtl/slbm_map.sv]
// slbm_map: mapper state (serial loader, control and bank registers, ROM sizes)
// and the combinational address mapping. Depends on slbm_pkg.
`default_nettype none

module slbm_map (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic                 cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 step_en,
    input  wire slbm_pkg::slbm_item_t item,
    output slbm_pkg::slbm_result_t    result
);

    logic [7:0] prg_count_reg, prg_count_next;
    logic [7:0] chr_count_reg, chr_count_next;
    logic [slbm_pkg::BANK_W-1:0] shift_reg, shift_next;
    logic [slbm_pkg::BANK_W-1:0] control_reg, control_next;
    logic [slbm_pkg::BANK_W-1:0] chr_low_reg, chr_low_next;
    logic [slbm_pkg::BANK_W-1:0] chr_high_reg, chr_high_next;
    logic [slbm_pkg::BANK_W-1:0] prg_sel_reg, prg_sel_next;

    logic [slbm_pkg::ADDR_W-1:0] a;
    logic [slbm_pkg::DATA_W-1:0] d;
    logic [1:0]                  prg_mode;
    logic [3:0]                  prg_bank;
    logic [7:0]                  last_bank;
    logic [slbm_pkg::MAP_W-1:0]  prg_off;
    logic [slbm_pkg::MAP_W-1:0]  chr_off;
    logic [slbm_pkg::BANK_W-1:0] shifted;

    assign a         = item.addr;
    assign d         = item.write_data;
    assign prg_mode  = control_reg[3:2];
    assign prg_bank  = prg_sel_reg[3:0];
    assign last_bank = prg_count_reg - 8'd1;
    assign shifted   = {d[0], shift_reg[slbm_pkg::BANK_W-1:1]};

    // PRG ROM offset; a[14] low means the 0x8000-0xBFFF half
    always_comb begin
        case (prg_mode)
            2'd2: begin
                if (!a[14]) prg_off = {8'd0, a[13:0]};
                else        prg_off = {4'd0, prg_bank, a[13:0]};
            end
            2'd3: begin
                if (!a[14]) prg_off = {4'd0, prg_bank, a[13:0]};
                else        prg_off = {last_bank, a[13:0]};
            end
            default: prg_off = {4'd0, prg_bank[3:1], a[14:0]};
        endcase
    end

    // CHR offset: RAM pass-through, 8K mode or two 4K banks
    always_comb begin
        if (chr_count_reg == 8'd0) begin
            chr_off = {6'd0, a};
        end else if (!control_reg[4]) begin
            chr_off = {5'd0, chr_low_reg[4:1], a[12:0]};
        end else if (!a[12]) begin
            chr_off = {5'd0, chr_low_reg, a[11:0]};
        end else begin
            chr_off = {5'd0, chr_high_reg, a[11:0]};
        end
    end

    // Access decode and register update
    always_comb begin
        result         = '0;
        result.target  = slbm_pkg::TGT_NONE;
        shift_next     = shift_reg;
        control_next   = control_reg;
        chr_low_next   = chr_low_reg;
        chr_high_next  = chr_high_reg;
        prg_sel_next   = prg_sel_reg;
        if (!item.kind[1]) begin
            if (a[15:13] == 3'b011) begin
                result.handled        = 1'b1;
                result.target         = slbm_pkg::TGT_PRG_RAM;
                result.mapped_address = {9'd0, a[12:0]};
            end else if (a[15]) begin
                result.handled = 1'b1;
                if (item.kind == slbm_pkg::KIND_CPU_READ) begin
                    result.target         = slbm_pkg::TGT_PRG_ROM;
                    result.mapped_address = prg_off;
                end else begin
                    result.target = slbm_pkg::TGT_REG;
                    if (d[7]) begin
                        shift_next   = slbm_pkg::SHIFT_RESET;
                        control_next = control_reg | slbm_pkg::CONTROL_RESET;
                    end else if (shift_reg[0]) begin
                        shift_next = slbm_pkg::SHIFT_RESET;
                        unique case (slbm_pkg::slbm_sel_t'(a[14:13]))
                            slbm_pkg::SEL_CONTROL: begin
                                control_next         = shifted;
                                result.mirror_update = 1'b1;
                                result.mirror_mode   = shifted[1:0];
                            end
                            slbm_pkg::SEL_CHR_LOW:  chr_low_next  = shifted;
                            slbm_pkg::SEL_CHR_HIGH: chr_high_next = shifted;
                            default:                prg_sel_next  = shifted;
                        endcase
                    end else begin
                        shift_next = shifted;
                    end
                end
            end
        end else if (a[15:13] == 3'b000) begin
            if (item.kind == slbm_pkg::KIND_PPU_READ) begin
                result.handled        = 1'b1;
                result.target         = slbm_pkg::TGT_CHR;
                result.mapped_address = chr_off;
            end else if (chr_count_reg == 8'd0) begin
                result.handled        = 1'b1;
                result.target         = slbm_pkg::TGT_CHR;
                result.mapped_address = {6'd0, a};
            end
        end
    end

    // Configuration writes
    always_comb begin
        prg_count_next = prg_count_reg;
        chr_count_next = chr_count_reg;
        if (cfg_we) begin
            if (cfg_index == slbm_pkg::CFG_PRG_COUNT) prg_count_next = cfg_data;
            else                                      chr_count_next = cfg_data;
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_count_reg <= slbm_pkg::PRG_CNT_RESET;
            chr_count_reg <= slbm_pkg::CHR_CNT_RESET;
            shift_reg     <= slbm_pkg::SHIFT_RESET;
            control_reg   <= slbm_pkg::CONTROL_RESET;
            chr_low_reg   <= '0;
            chr_high_reg  <= '0;
            prg_sel_reg   <= '0;
        end else begin
            prg_count_reg <= prg_count_next;
            chr_count_reg <= chr_count_next;
            if (step_en) begin
                shift_reg    <= shift_next;
                control_reg  <= control_next;
                chr_low_reg  <= chr_low_next;
                chr_high_reg <= chr_high_next;
                prg_sel_reg  <= prg_sel_next;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/serial_loaded_bank_mapper.sv]
// serial_loaded_bank_mapper: cartridge bus mapper with serially loaded bank
// registers. Usage notes:
//   s_ channel: one bus access per transfer; tuser carries the access kind,
//     tdata carries the address and the write data byte.
//   m_ channel: one result per access, in order; tuser carries handled and
//     target, tdata the mapped offset and the mirroring update.
//   cfg port: cfg_we writes cfg_data into the ROM bank count selected by
//     cfg_index (0 PRG count, 1 CHR count); write only while idle.
//   Path: an accepted access is held in the input register, then its result in
//     the result register, from which it is offered on the m_ channel.
//   Throughput: one access per cycle while m_tready stays high; the serial
//     loader and bank logic settle in one pass between the two registers.
//   Stall: while m_tready is low the result holds; one more access may wait
//     in the input register, after which s_tready drops.
//   Reset: loader at its marker value, control 0x0C, banks zero, PRG count 2,
//     CHR count 0 (CHR RAM), both registers empty.
// Depends on slbm_pkg and slbm_map.
`default_nettype none

module serial_loaded_bank_mapper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [15:0] addr, [23:16] write_data
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [21:0] mapped_address, [22] mirror_update,
                                        // [24:23] mirror_mode, [31:25] zero
    output logic [3:0]       m_tuser,   // [0] handled, [3:1] target
    // configuration
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    logic                   in_valid_reg, in_valid_next;
    slbm_pkg::slbm_item_t   in_item_reg;
    logic                   out_valid_reg, out_valid_next;
    slbm_pkg::slbm_result_t out_res_reg;
    slbm_pkg::slbm_result_t map_res;
    logic                   advance;
    logic                   s_xfer;

    // Item moves to the result register when that register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_xfer || (in_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !m_tready);
    end

    slbm_map u_map (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_en   (advance),
        .item      (in_item_reg),
        .result    (map_res)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_item_reg.kind       <= slbm_pkg::slbm_kind_t'(s_tuser);
            in_item_reg.addr       <= s_tdata[15:0];
            in_item_reg.write_data <= s_tdata[23:16];
        end
        if (advance) begin
            out_res_reg <= map_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.mirror_mode, out_res_reg.mirror_update,
                       out_res_reg.mapped_address};
    assign m_tuser  = {out_res_reg.target, out_res_reg.handled};

endmodule

`default_nettype wire

[tb/sv/serial_loaded_bank_mapper_test.sv]
// Self-checking testbench for serial_loaded_bank_mapper: drives bus accesses and ROM
// bank counts, predicts every result in place and compares it field by field.
// Depends on slbm_pkg and the serial_loaded_bank_mapper RTL.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_test;
    import slbm_pkg::*;

    localparam int ACCESSES_PER_PHASE = 235;
    localparam int STALL_LIMIT        = 1000;
    localparam int MAX_REPORTS        = 10;

    // PRG banking modes from control bits 3:2; lower codes switch 32K
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
    // control bits forced by a loader reset write
    localparam logic [BANK_W-1:0] PRG_MODE_BITS = 5'b01100;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_PRG_COUNT;
    logic [7:0]  cfg_data  = '0;

    // mapper state mirrored by the predictor
    logic [BANK_W-1:0] load_shift  = SHIFT_RESET;
    logic [BANK_W-1:0] control_reg = CONTROL_RESET;
    logic [BANK_W-1:0] chr_low     = '0;
    logic [BANK_W-1:0] chr_high    = '0;
    logic [BANK_W-1:0] prg_select  = '0;
    logic [7:0]        prg_count   = PRG_CNT_RESET;
    logic [7:0]        chr_count   = CHR_CNT_RESET;

    slbm_item_t   access_q[$];
    slbm_result_t result_q[$];

    logic s_take = 1'b0;
    logic calm   = 1'b0;
    int   s_gap  = 0;
    int   m_gap  = 0;
    int   idle_cycles    = 0;
    int   mismatch_count = 0;

    serial_loaded_bank_mapper DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [MAP_W-1:0] prg_offset(logic [ADDR_W-1:0] a);
        logic [3:0] bank;
        logic [7:0] last_bank;
        bank      = prg_select[3:0];
        last_bank = prg_count - 8'd1;
        // a[15] is set here, so a[14] tells upper from lower 16K window
        case (control_reg[3:2])
            PRG_MODE_FIX_FIRST:
                return a[14] ? {4'b0, bank, a[13:0]} : {8'b0, a[13:0]};
            PRG_MODE_FIX_LAST:
                return a[14] ? {last_bank, a[13:0]} : {4'b0, bank, a[13:0]};
            default:
                return {4'b0, bank[3:1], a[14:0]};
        endcase
    endfunction

    function automatic logic [MAP_W-1:0] chr_offset(logic [ADDR_W-1:0] a);
        if (chr_count == 8'd0) return {6'b0, a};
        if (!control_reg[4]) return {5'b0, chr_low[4:1], a[12:0]};
        if (!a[12]) return {5'b0, chr_low, a[11:0]};
        return {5'b0, chr_high, a[11:0]};
    endfunction

    // expected result of one access; updates the serial loader and bank registers
    function automatic slbm_result_t map_access(slbm_item_t acc);
        slbm_result_t res;
        logic [BANK_W-1:0] shifted;
        res = '0;
        if (acc.kind == KIND_CPU_READ || acc.kind == KIND_CPU_WRITE) begin
            if (acc.addr >= 16'h6000 && acc.addr <= 16'h7FFF) begin
                res.handled        = 1'b1;
                res.target         = TGT_PRG_RAM;
                res.mapped_address = {9'b0, acc.addr[12:0]};
            end else if (acc.addr[15]) begin
                res.handled = 1'b1;
                if (acc.kind == KIND_CPU_READ) begin
                    res.target         = TGT_PRG_ROM;
                    res.mapped_address = prg_offset(acc.addr);
                end else begin
                    res.target = TGT_REG;
                    if (acc.write_data[7]) begin
                        load_shift  = SHIFT_RESET;
                        control_reg = control_reg | PRG_MODE_BITS;
                    end else begin
                        shifted = {acc.write_data[0], load_shift[4:1]};
                        // marker bit reached bit 0: this is the fifth bit
                        if (load_shift[0]) begin
                            case (slbm_sel_t'(acc.addr[14:13]))
                                SEL_CONTROL: begin
                                    control_reg       = shifted;
                                    res.mirror_update = 1'b1;
                                    res.mirror_mode   = shifted[1:0];
                                end
                                SEL_CHR_LOW:  chr_low  = shifted;
                                SEL_CHR_HIGH: chr_high = shifted;
                                default:      prg_select = shifted;
                            endcase
                            load_shift = SHIFT_RESET;
                        end else begin
                            load_shift = shifted;
                        end
                    end
                end
            end
        end else if (acc.addr < 16'h2000) begin
            if (acc.kind == KIND_PPU_READ) begin
                res.handled        = 1'b1;
                res.target         = TGT_CHR;
                res.mapped_address = chr_offset(acc.addr);
            end else if (chr_count == 8'd0) begin
                res.handled        = 1'b1;
                res.target         = TGT_CHR;
                res.mapped_address = {6'b0, acc.addr};
            end
        end
        return res;
    endfunction

    // input side: capture transfers at the rising edge and predict
    always @(posedge aclk) begin
        s_take = aresetn && s_tvalid && s_tready;
        if (s_take)
            result_q.push_back(map_access('{kind: slbm_kind_t'(s_tuser),
                                            addr: s_tdata[15:0],
                                            write_data: s_tdata[23:16]}));
    end

    // input side: present the next access at the falling edge
    always @(negedge aclk) begin
        if (!s_tvalid || s_take) begin
            if (s_gap > 0) begin
                s_gap = s_gap - 1;
                s_tvalid <= 1'b0;
            end else if (access_q.size() != 0) begin
                slbm_item_t nxt;
                nxt = access_q.pop_front();
                s_tdata  <= {nxt.write_data, nxt.addr};
                s_tuser  <= nxt.kind;
                s_tvalid <= 1'b1;
                s_gap = idle_len();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random backpressure
    always @(negedge aclk) begin
        if (m_gap > 0) begin
            m_gap = m_gap - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_gap = idle_len();
        end
    end

    task automatic check_field(string name, logic [MAP_W-1:0] want, logic [MAP_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // result side: compare each transfer with the oldest prediction
    always @(posedge aclk) begin
        if ($urandom_range(0, 299) == 0) calm = !calm;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: tuser %0h tdata %0h", m_tuser, m_tdata);
            end else begin
                slbm_result_t want;
                want = result_q.pop_front();
                check_field("handled", MAP_W'(want.handled), MAP_W'(m_tuser[0]));
                check_field("target", MAP_W'(want.target), MAP_W'(m_tuser[3:1]));
                check_field("mapped_address", want.mapped_address, m_tdata[21:0]);
                check_field("mirror_update", MAP_W'(want.mirror_update),
                            MAP_W'(m_tdata[22]));
                check_field("mirror_mode", MAP_W'(want.mirror_mode),
                            MAP_W'(m_tdata[24:23]));
            end
        end
    end

    // watchdog: no transfer on either side for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_access(slbm_kind_t kind, logic [15:0] addr, logic [7:0] data);
        access_q.push_back('{kind: kind, addr: addr, write_data: data});
    endtask

    // five serial writes; only the last address picks the register
    task automatic load_register(slbm_sel_t sel, logic [BANK_W-1:0] value);
        logic [1:0] region;
        for (int i = 0; i < BANK_W; i++) begin
            region = (i == BANK_W - 1) ? sel : 2'($urandom);
            push_access(KIND_CPU_WRITE, {1'b1, region, 13'($urandom)},
                        {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic write_count(logic idx, logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_PRG_COUNT)
            prg_count = value;
        else
            chr_count = value;
    endtask

    task automatic wait_idle();
        while (access_q.size() != 0 || s_tvalid || result_q.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // random traffic, mostly complete register loads and mapped reads
    task automatic queue_random(int count);
        int queued;
        int r;
        queued = 0;
        while (queued < count) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_access(KIND_CPU_WRITE, 16'($urandom_range(16'h8000, 16'hFFFF)),
                                {1'b1, 7'($urandom)});
                    queued++;
                end
                load_register(slbm_sel_t'($urandom_range(0, 3)), 5'($urandom));
                queued += BANK_W;
            end else if (r < 55) begin
                push_access(KIND_CPU_READ, 16'($urandom_range(16'h6000, 16'hFFFF)),
                            8'($urandom));
                queued++;
            end else if (r < 75) begin
                push_access(KIND_PPU_READ, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
                queued++;
            end else if (r < 83) begin
                push_access(KIND_PPU_WRITE, 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
                queued++;
            end else begin
                push_access(slbm_kind_t'($urandom_range(0, 3)), 16'($urandom),
                            8'($urandom));
                queued++;
            end
        end
    endtask

    initial begin
        logic [7:0] prg_setting [7] = '{8'd1, 8'd255, 8'd0, 8'd16, 8'd0, 8'd0, 8'd0};
        logic [7:0] chr_setting [7] = '{8'd1, 8'd255, 8'd0, 8'd32, 8'd0, 8'd0, 8'd0};

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed accesses under the reset bank counts
        push_access(KIND_CPU_READ,  16'h0000, 8'h00);   // unclaimed
        push_access(KIND_CPU_READ,  16'h6000, 8'h00);   // PRG RAM
        push_access(KIND_CPU_WRITE, 16'h7FFF, 8'hFF);   // PRG RAM write
        push_access(KIND_CPU_READ,  16'h8000, 8'h00);   // fixed-last mode
        push_access(KIND_CPU_READ,  16'hFFFF, 8'h00);
        push_access(KIND_CPU_WRITE, 16'h8000, 8'h80);   // loader reset
        load_register(SEL_CONTROL, 5'h13);               // 4K CHR, 32K PRG, mirroring 3
        load_register(SEL_PRG, 5'h0F);
        push_access(KIND_CPU_READ,  16'hBFFF, 8'h00);
        push_access(KIND_PPU_READ,  16'h0000, 8'h00);   // CHR RAM pass-through
        push_access(KIND_PPU_READ,  16'h1FFF, 8'h00);
        push_access(KIND_PPU_WRITE, 16'h1FFF, 8'h55);
        push_access(KIND_PPU_READ,  16'h2000, 8'h00);   // above pattern space
        push_access(KIND_PPU_WRITE, 16'hFFFF, 8'hFF);
        push_access(KIND_CPU_WRITE, 16'h5FFF, 8'h00);   // unclaimed write
        push_access(KIND_CPU_WRITE, 16'hA000, 8'h01);   // partial load, then reset
        push_access(KIND_CPU_WRITE, 16'hA000, 8'h80);
        queue_random(ACCESSES_PER_PHASE);
        wait_idle();

        // later phases: extremes first, then random counts
        for (int p = 0; p < 7; p++) begin
            if (p >= 4) begin
                prg_setting[p] = 8'($urandom_range(1, 255));
                chr_setting[p] = ($urandom_range(0, 2) == 0) ? 8'd0 :
                                 8'($urandom_range(1, 255));
            end
            write_count(CFG_PRG_COUNT, prg_setting[p]);
            write_count(CFG_CHR_COUNT, chr_setting[p]);
            @(posedge aclk);
            queue_random(ACCESSES_PER_PHASE);
            wait_idle();
        end

        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
